>>> sv/mtdf_pkg.sv
// Package for the message TID duplicate filter.
// Holds the record type, field widths and reset constants shared by the cell and the top level.
// No dependencies.
package mtdf_pkg;

    localparam int ENTRIES_DEFAULT = 20;

    localparam int ADDR_W   = 16;
    localparam int TID_W    = 8;
    localparam int TIME_W   = 32;
    localparam int WINDOW_W = 16;

    localparam logic [WINDOW_W-1:0] WINDOW_RESET = 16'd6000;

    localparam logic STATUS_ACCEPTED = 1'b0;
    localparam logic STATUS_REPEAT   = 1'b1;

    typedef struct packed {
        logic [TID_W-1:0]  tid;
        logic [ADDR_W-1:0] addr;
        logic [TIME_W-1:0] stamp;
    } record_t;

endpackage

>>> sv/mtdf_cell.sv
// One record cell of the duplicate filter chain.
// Holds one record, compares it against the incoming beat and hands it on when the chain shifts.
// Depends on mtdf_pkg.
module mtdf_cell (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             shift_en,
    input  mtdf_pkg::record_t                rec_in,
    output mtdf_pkg::record_t                rec_out,
    input  logic [mtdf_pkg::TID_W-1:0]       probe_tid,
    input  logic [mtdf_pkg::ADDR_W-1:0]      probe_addr,
    input  logic [mtdf_pkg::TIME_W-1:0]      probe_now,
    input  logic [mtdf_pkg::WINDOW_W-1:0]    window,
    output logic                             hit
);

    mtdf_pkg::record_t              rec_reg;
    mtdf_pkg::record_t              rec_next;
    logic [mtdf_pkg::TIME_W-1:0]    window_end;

    // The end of the window wraps modulo 2^32, exactly like the stored time arithmetic.
    assign window_end = rec_reg.stamp
                      + {{(mtdf_pkg::TIME_W-mtdf_pkg::WINDOW_W){1'b0}}, window};

    assign hit = (rec_reg.tid == probe_tid) && (rec_reg.addr == probe_addr)
              && (probe_now < window_end);

    assign rec_next = shift_en ? rec_in : rec_reg;
    assign rec_out  = rec_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rec_reg <= '0;
        end else begin
            rec_reg <= rec_next;
        end
    end

endmodule

>>> sv/message_tid_duplicate_filter_top.sv
// Top level of the message TID duplicate filter.
// Instantiates a chain of mtdf_cell records and holds the window register and result register.
// Depends on mtdf_pkg and mtdf_cell.
//
//   Channel   Direction  Handshake            Beat contents
//   s_        in         s_valid / s_ready    s_source_address, s_transaction_id, s_now_ms
//   m_        out        m_valid / m_ready    m_status
//   cfg_      in         cfg_valid/cfg_ready  cfg_window_ms
//
// Every input beat is decided in the cycle it is accepted: each cell compares its record in
// parallel and the hits are OR-reduced, so the filter sustains one beat per clock cycle
// while the consumer keeps up. The output register holds the result; a new input beat is taken
// when that register is empty or drained, so a stalled consumer stalls the input only then.
// Synchronous active-low reset clears every record to tid 0, address 0, time 0, sets the window
// to 6000 ms and empties the output register. The configuration channel is always ready.
//
// The ring of records with a write slot is built as a shift chain: an accepted (non-repeat) beat
// enters cell 0 and every record moves one cell along, dropping the oldest off the far end. The
// set of stored records is the same as the ring's, and matching does not depend on position.
module message_tid_duplicate_filter_top #(
    parameter int ENTRIES = mtdf_pkg::ENTRIES_DEFAULT
) (
    input  logic                             aclk,
    input  logic                             aresetn,

    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [mtdf_pkg::ADDR_W-1:0]      s_source_address,
    input  logic [mtdf_pkg::TID_W-1:0]       s_transaction_id,
    input  logic [mtdf_pkg::TIME_W-1:0]      s_now_ms,

    output logic                             m_valid,
    input  logic                             m_ready,
    output logic                             m_status,

    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [mtdf_pkg::WINDOW_W-1:0]    cfg_window_ms
);

    logic [mtdf_pkg::WINDOW_W-1:0]  window_reg;
    logic [mtdf_pkg::WINDOW_W-1:0]  window_next;
    logic                           m_valid_reg;
    logic                           m_valid_next;
    logic                           m_status_reg;
    logic                           m_status_next;

    logic                           s_accept;
    logic                           shift_en;
    logic                           hit_any;
    logic [ENTRIES-1:0]             hit_vec;
    mtdf_pkg::record_t              new_rec;
    mtdf_pkg::record_t              cell_rec [ENTRIES];

    assign cfg_ready = 1'b1;
    assign s_ready   = !m_valid_reg || m_ready;
    assign s_accept  = s_valid && s_ready;
    assign hit_any   = |hit_vec;

    // Only a beat that found no live match is recorded.
    assign shift_en  = s_accept && !hit_any;

    assign new_rec.tid   = s_transaction_id;
    assign new_rec.addr  = s_source_address;
    assign new_rec.stamp = s_now_ms;

    // The chain of record cells; cell 0 takes the new record, each later cell its neighbor's.
    for (genvar k = 0; k < ENTRIES; k++) begin : g_cell
        mtdf_pkg::record_t chain_in;
        if (k == 0) begin : g_head
            assign chain_in = new_rec;
        end else begin : g_link
            assign chain_in = cell_rec[k-1];
        end
        mtdf_cell u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .shift_en   (shift_en),
            .rec_in     (chain_in),
            .rec_out    (cell_rec[k]),
            .probe_tid  (s_transaction_id),
            .probe_addr (s_source_address),
            .probe_now  (s_now_ms),
            .window     (window_reg),
            .hit        (hit_vec[k])
        );
    end

    always_comb begin
        window_next   = window_reg;
        m_valid_next  = m_valid_reg;
        m_status_next = m_status_reg;
        if (cfg_valid && cfg_ready) begin
            window_next = cfg_window_ms;
        end
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (s_accept) begin
            m_valid_next  = 1'b1;
            m_status_next = hit_any ? mtdf_pkg::STATUS_REPEAT : mtdf_pkg::STATUS_ACCEPTED;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_reg  <= mtdf_pkg::WINDOW_RESET;
            m_valid_reg <= 1'b0;
        end else begin
            window_reg  <= window_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // The status bit is payload and needs no reset.
    always_ff @(posedge aclk) begin
        m_status_reg <= m_status_next;
    end

    assign m_valid  = m_valid_reg;
    assign m_status = m_status_reg;

    // A recorded beat lands in the head cell.
    a_head_written: assert property (@(posedge aclk) disable iff (!aresetn)
        shift_en |=> (cell_rec[0].tid == $past(s_transaction_id))
                  && (cell_rec[0].addr == $past(s_source_address))
                  && (cell_rec[0].stamp == $past(s_now_ms)))
        else $error("accepted beat was not written into the head cell");

    // A repeat leaves the store untouched; the head cell and the last cell are checked.
    a_repeat_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && hit_any) |=> $stable(cell_rec[0]) && $stable(cell_rec[ENTRIES-1]))
        else $error("repeat beat changed the record store");

    // Every accepted beat produces a result carrying its match outcome.
    a_result_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> m_valid && (m_status == $past(hit_any)))
        else $error("result missing or wrong after an accepted beat");

    // A result beat that the consumer has not taken stays valid and unchanged.
    a_result_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> m_valid && $stable(m_status))
        else $error("waiting result beat dropped or changed");

endmodule
